### src/p2ad_pkg.sv
`default_nettype none

package p2ad_pkg;

   localparam int PIXEL_W    = 32;
   localparam int CHAN_W     = 8;
   localparam int SUM_W      = CHAN_W + 1;
   localparam int CFG_DIM_W  = 12;
   localparam int CFG_FMT_W  = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int MAX_HEIGHT_DEFAULT = 2048;

   localparam int CH5_MAX  = 31;
   localparam int CH6_MAX  = 63;
   localparam int CH_FULL  = 255;

   typedef logic [CFG_FMT_W-1:0] fmt_type;
   localparam fmt_type FMT_RGB565 = 2'd0;
   localparam fmt_type FMT_BGRX32 = 2'd1;
   localparam fmt_type FMT_RGB24  = 2'd2;

   typedef logic [REG_IDX_W-1:0] reg_index_type;
   localparam reg_index_type REG_FRAME_WIDTH  = 2'd0;
   localparam reg_index_type REG_FRAME_HEIGHT = 2'd1;
   localparam reg_index_type REG_PIXEL_FORMAT = 2'd2;

   localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
   localparam fmt_type              PIXEL_FORMAT_RESET = FMT_RGB24;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } rgb_sum_type;

   typedef struct packed {
      logic                 restart;
      logic [CFG_DIM_W-1:0] frame_width;
      logic [CFG_DIM_W-1:0] frame_height;
      fmt_type              pixel_format;
   } csr_ctrl_type;

   typedef logic [CHAN_W-1:0] exp5_table_type [32];
   typedef logic [CHAN_W-1:0] exp6_table_type [64];

   function automatic exp5_table_type build_exp5();
      exp5_table_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = CHAN_W'((i * CH_FULL) / CH5_MAX);
      end
      return t;
   endfunction

   function automatic exp6_table_type build_exp6();
      exp6_table_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = CHAN_W'((i * CH_FULL) / CH6_MAX);
      end
      return t;
   endfunction

   localparam exp5_table_type EXPAND5 = build_exp5();
   localparam exp6_table_type EXPAND6 = build_exp6();

   function automatic rgb_sum_type decode_pixel(input logic [PIXEL_W-1:0] w, input fmt_type fmt);
      rgb_sum_type p;
      case (fmt)
         FMT_RGB565: begin
            p.red   = SUM_W'(EXPAND5[w[15:11]]);
            p.green = SUM_W'(EXPAND6[w[10:5]]);
            p.blue  = SUM_W'(EXPAND5[w[4:0]]);
         end
         FMT_BGRX32: begin
            p.blue  = SUM_W'(w[7:0]);
            p.green = SUM_W'(w[15:8]);
            p.red   = SUM_W'(w[23:16]);
         end
         default: begin
            p.red   = SUM_W'(w[7:0]);
            p.green = SUM_W'(w[15:8]);
            p.blue  = SUM_W'(w[23:16]);
         end
      endcase
      return p;
   endfunction

   function automatic rgb_sum_type rgb_add(input rgb_sum_type a, input rgb_sum_type b);
      rgb_sum_type s;
      s.red   = a.red + b.red;
      s.green = a.green + b.green;
      s.blue  = a.blue + b.blue;
      return s;
   endfunction

endpackage

`default_nettype wire

### src/p2ad_ram.sv
`default_nettype none

module p2ad_ram #(
   parameter int WIDTH  = 27,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### src/p2ad_csr.sv
`default_nettype none

module p2ad_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [p2ad_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [p2ad_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [p2ad_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output p2ad_pkg::csr_ctrl_type              ctrl
);

   import p2ad_pkg::*;

   logic [CFG_DIM_W-1:0] frame_width_ff;
   logic [CFG_DIM_W-1:0] frame_height_ff;
   fmt_type              pixel_format_ff;
   logic                 write_beat;
   reg_index_type        reg_index;
   logic                 known_reg;

   assign pready     = 1'b1;
   assign reg_index  = paddr[CSR_ADDR_W-1:2];
   assign write_beat = psel && penable && pwrite && pready;
   assign known_reg  = reg_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_PIXEL_FORMAT};

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         pixel_format_ff <= PIXEL_FORMAT_RESET;
      end else if (write_beat) begin
         case (reg_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[CFG_DIM_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= pwdata[CFG_DIM_W-1:0];
            REG_PIXEL_FORMAT: pixel_format_ff <= pwdata[CFG_FMT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_FRAME_WIDTH:  prdata = CSR_DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = CSR_DATA_W'(frame_height_ff);
         REG_PIXEL_FORMAT: prdata = CSR_DATA_W'(pixel_format_ff);
         default:          prdata = '0;
      endcase
   end

   assign ctrl.restart      = write_beat && known_reg;
   assign ctrl.frame_width  = frame_width_ff;
   assign ctrl.frame_height = frame_height_ff;
   assign ctrl.pixel_format = pixel_format_ff;

endmodule

`default_nettype wire

### src/pixel_2x2_average_downscaler.sv
`default_nettype none

// 2x2 box-filter downscaler. Source pixels (RGB565, 32-bit B,G,R,X or 24-bit R,G,B, chosen by
// pixel_format) enter in raster order on the req channel, one beat per pixel, and one averaged
// B,G,R pixel leaves on the rsp channel for each complete 2x2 block, with row_end and frame_end
// marks; an odd last column or row is consumed without output. The block takes one pixel per
// clock while req_stall is low: a pixel is decoded and paired at the input, the pair sums of
// each even row wait in a line RAM of MAX_WIDTH/2 entries with one write or one read per beat,
// and a result passes the stage-1 and result registers. A result held by rsp_stall lets one more
// into stage 1 before req_stall rises; a known-register write restarts the frame at row 0, column 0.
module pixel_2x2_average_downscaler #(
   parameter int MAX_WIDTH  = p2ad_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = p2ad_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [p2ad_pkg::PIXEL_W-1:0]        req_pixel_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [p2ad_pkg::CHAN_W-1:0]         rsp_blue,
   output logic [p2ad_pkg::CHAN_W-1:0]         rsp_green,
   output logic [p2ad_pkg::CHAN_W-1:0]         rsp_red,
   output logic                                rsp_row_end,
   output logic                                rsp_frame_end,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [p2ad_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [p2ad_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [p2ad_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   import p2ad_pkg::*;

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int WDIM_W     = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP_W     = (WDIM_W > CFG_DIM_W) ? WDIM_W : CFG_DIM_W;
   localparam int HCMP_W     = (HDIM_W > CFG_DIM_W) ? HDIM_W : CFG_DIM_W;
   localparam int RGB_W      = $bits(rgb_sum_type);

   csr_ctrl_type ctrl;

   logic [WCMP_W-1:0] width_raw;
   logic [HCMP_W-1:0] height_raw;
   logic [WDIM_W-1:0] width_dim;
   logic [HDIM_W-1:0] height_dim;
   logic [WDIM_W-1:0] last_col;
   logic [HDIM_W-1:0] last_row;
   logic [WDIM_W-1:0] col_ext;
   logic [WDIM_W-1:0] col_next;
   logic [HDIM_W-1:0] row_ext;
   logic [HDIM_W-1:0] row_next;

   logic [COL_W-1:0]  column_count_ff;
   logic [COL_W-1:0]  column_count_in;
   logic [ROW_W-1:0]  row_count_ff;
   logic [ROW_W-1:0]  row_count_in;
   rgb_sum_type       pair_sum_hold_ff;
   rgb_sum_type       pair_sum_hold_in;

   rgb_sum_type       pixel;
   rgb_sum_type       pair;
   logic              col_pair;
   logic              row_pair;
   logic              emit;
   logic              req_accept;
   logic              line_wr;
   logic              line_rd;
   logic [LINE_AW-1:0] line_addr;
   logic [RGB_W-1:0]   line_rd_data;
   rgb_sum_type        line_above;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   rgb_sum_type       s1_pair_ff;
   logic              s1_row_end_ff;
   logic              s1_frame_end_ff;
   logic              s1_move;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CHAN_W-1:0] rsp_blue_ff;
   logic [CHAN_W-1:0] rsp_green_ff;
   logic [CHAN_W-1:0] rsp_red_ff;
   logic              rsp_row_end_ff;
   logic              rsp_frame_end_ff;
   logic [SUM_W:0]    blue_sum;
   logic [SUM_W:0]    green_sum;
   logic [SUM_W:0]    red_sum;

   p2ad_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .ctrl    (ctrl)
   );

   assign width_raw  = WCMP_W'(ctrl.frame_width);
   assign height_raw = HCMP_W'(ctrl.frame_height);

   always_comb begin
      if (width_raw < WCMP_W'(2)) begin
         width_dim = WDIM_W'(2);
      end else if (width_raw > WCMP_W'(MAX_WIDTH)) begin
         width_dim = WDIM_W'(MAX_WIDTH);
      end else begin
         width_dim = WDIM_W'(width_raw);
      end
      if (height_raw < HCMP_W'(2)) begin
         height_dim = HDIM_W'(2);
      end else if (height_raw > HCMP_W'(MAX_HEIGHT)) begin
         height_dim = HDIM_W'(MAX_HEIGHT);
      end else begin
         height_dim = HDIM_W'(height_raw);
      end
   end

   assign last_col = (width_dim & ~WDIM_W'(1)) - WDIM_W'(1);
   assign last_row = (height_dim & ~HDIM_W'(1)) - HDIM_W'(1);
   assign col_ext  = WDIM_W'(column_count_ff);
   assign row_ext  = HDIM_W'(row_count_ff);
   assign col_next = col_ext + WDIM_W'(1);
   assign row_next = row_ext + HDIM_W'(1);

   assign col_pair = column_count_ff[0] && (col_ext <= last_col);
   assign row_pair = row_count_ff[0] && (row_ext <= last_row);
   assign emit     = col_pair && row_pair;

   assign pixel = decode_pixel(req_pixel_word, ctrl.pixel_format);
   assign pair  = rgb_add(pair_sum_hold_ff, pixel);

   // hold the stage-1 beat while the result register is full and stalled
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   assign line_addr = LINE_AW'(column_count_ff >> 1);
   assign line_wr   = req_accept && col_pair && !row_count_ff[0];
   assign line_rd   = req_accept && emit;

   p2ad_ram #(
      .WIDTH  (RGB_W),
      .DEPTH  (LINE_DEPTH),
      .ADDR_W (LINE_AW)
   ) u_line (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (line_addr),
      .wr_data (pair),
      .rd_en   (line_rd),
      .rd_addr (line_addr),
      .rd_data (line_rd_data)
   );

   assign line_above = line_rd_data;

   always_comb begin
      column_count_in  = column_count_ff;
      row_count_in     = row_count_ff;
      pair_sum_hold_in = pair_sum_hold_ff;
      if (ctrl.restart) begin
         column_count_in  = '0;
         row_count_in     = '0;
         pair_sum_hold_in = '0;
      end else if (req_accept) begin
         if (!column_count_ff[0]) begin
            pair_sum_hold_in = pixel;
         end
         if (col_next >= width_dim) begin
            column_count_in = '0;
            row_count_in    = (row_next >= height_dim) ? '0 : ROW_W'(row_next);
         end else begin
            column_count_in = COL_W'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         pair_sum_hold_ff <= '0;
      end else begin
         column_count_ff  <= column_count_in;
         row_count_ff     <= row_count_in;
         pair_sum_hold_ff <= pair_sum_hold_in;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept && emit) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         s1_pair_ff      <= pair;
         s1_row_end_ff   <= (col_ext == last_col);
         s1_frame_end_ff <= (col_ext == last_col) && (row_ext == last_row);
      end
   end

   assign blue_sum  = (SUM_W + 1)'(line_above.blue) + (SUM_W + 1)'(s1_pair_ff.blue);
   assign green_sum = (SUM_W + 1)'(line_above.green) + (SUM_W + 1)'(s1_pair_ff.green);
   assign red_sum   = (SUM_W + 1)'(line_above.red) + (SUM_W + 1)'(s1_pair_ff.red);

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_blue_ff      <= blue_sum[SUM_W:2];
         rsp_green_ff     <= green_sum[SUM_W:2];
         rsp_red_ff       <= red_sum[SUM_W:2];
         rsp_row_end_ff   <= s1_row_end_ff;
         rsp_frame_end_ff <= s1_frame_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_blue      = rsp_blue_ff;
   assign rsp_green     = rsp_green_ff;
   assign rsp_red       = rsp_red_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   a_line_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(line_wr && line_rd))
      else $error("line RAM written and read in the same beat");

   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ext < width_dim)
      else $error("column count beyond frame width");

   a_emit_reaches_stage1: assert property (@(posedge clock) disable iff (reset)
      (req_accept && emit && !ctrl.restart) |=> s1_valid_ff)
      else $error("block result lost at stage 1");

   a_frame_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_frame_end_ff || rsp_row_end_ff))
      else $error("frame end without row end");

endmodule

`default_nettype wire

### tb/tb_pixel_2x2_average_downscaler.sv
`default_nettype none

module tb_pixel_2x2_average_downscaler;
   import p2ad_pkg::*;

   localparam int LINE_DEPTH = MAX_WIDTH_DEFAULT / 2;
   localparam int IDLE_PCT = 37;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_BEATS = 1600;
   localparam int CALM_PHASE = 4;
   localparam int CALM_WIDTH = MAX_WIDTH_DEFAULT / 8;
   localparam reg_index_type REG_SPARE = 2'd3;
   localparam fmt_type FMT_RGB24_ALT = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic              row_end;
      logic              frame_end;
   } pixel_out_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] word;
      logic               typed;
      pixel_out_type      want;
   } pixel_beat_type;

   typedef enum logic [1:0] {STEP_WRITE, STEP_READ, STEP_PIXEL} step_kind_type;

   typedef struct packed {
      step_kind_type      kind;
      reg_index_type      idx;
      logic [31:0]        value;
      logic               typed;
      pixel_out_type      want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIXEL_W-1:0]    req_pixel_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAN_W-1:0]     rsp_blue;
   logic [CHAN_W-1:0]     rsp_green;
   logic [CHAN_W-1:0]     rsp_red;
   logic                  rsp_row_end;
   logic                  rsp_frame_end;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // shadow of the block's registers and frame state
   logic [CFG_DIM_W-1:0]  cfg_width = FRAME_WIDTH_RESET;
   logic [CFG_DIM_W-1:0]  cfg_height = FRAME_HEIGHT_RESET;
   fmt_type               cfg_format = PIXEL_FORMAT_RESET;
   rgb_sum_type           pair_line [LINE_DEPTH];
   rgb_sum_type           pair_hold = '0;
   int unsigned           col_pos = 0;
   int unsigned           row_pos = 0;

   pixel_beat_type        pixel_q[$];
   pixel_out_type         block_avg_q[$];
   stim_row_type          stim_table[$];
   int unsigned           beats_queued = 0;
   int unsigned           beats_taken = 0;
   int unsigned           errors = 0;
   bit                    calm = 1'b0;
   bit                    hold_ask = 1'b0;
   bit                    hold_done = 1'b0;
   int unsigned           hold_left = 0;

   pixel_2x2_average_downscaler dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_word(req_pixel_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_blue      (rsp_blue),
      .rsp_green     (rsp_green),
      .rsp_red       (rsp_red),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #4 clock = ~clock;

   function automatic rgb_sum_type expand_pixel(input logic [PIXEL_W-1:0] w);
      rgb_sum_type p;
      case (cfg_format)
         FMT_RGB565: begin
            p.red   = SUM_W'((int'(w[15:11]) * 255) / 31);
            p.green = SUM_W'((int'(w[10:5]) * 255) / 63);
            p.blue  = SUM_W'((int'(w[4:0]) * 255) / 31);
         end
         FMT_BGRX32: begin
            p.blue  = {1'b0, w[7:0]};
            p.green = {1'b0, w[15:8]};
            p.red   = {1'b0, w[23:16]};
         end
         default: begin
            p.red   = {1'b0, w[7:0]};
            p.green = {1'b0, w[15:8]};
            p.blue  = {1'b0, w[23:16]};
         end
      endcase
      return p;
   endfunction

   task automatic downscale_beat(input logic [PIXEL_W-1:0] w, output bit made,
                                 output pixel_out_type res);
      int unsigned wd;
      int unsigned ht;
      int unsigned last_col;
      int unsigned last_row;
      rgb_sum_type pix;
      rgb_sum_type pair;
      rgb_sum_type above;
      wd = (cfg_width < 2) ? 2 :
           (cfg_width > MAX_WIDTH_DEFAULT) ? MAX_WIDTH_DEFAULT : cfg_width;
      ht = (cfg_height < 2) ? 2 :
           (cfg_height > MAX_HEIGHT_DEFAULT) ? MAX_HEIGHT_DEFAULT : cfg_height;
      last_col = (wd & ~1) - 1;
      last_row = (ht & ~1) - 1;
      pix = expand_pixel(w);
      made = 1'b0;
      res = '0;
      if (col_pos[0] == 1'b0) begin
         pair_hold = pix;
      end else if (col_pos <= last_col) begin
         pair.red   = pair_hold.red + pix.red;
         pair.green = pair_hold.green + pix.green;
         pair.blue  = pair_hold.blue + pix.blue;
         if (row_pos[0] == 1'b0) begin
            pair_line[col_pos >> 1] = pair;
         end else if (row_pos <= last_row) begin
            above = pair_line[col_pos >> 1];
            res.blue  = CHAN_W'(({1'b0, above.blue} + {1'b0, pair.blue}) >> 2);
            res.green = CHAN_W'(({1'b0, above.green} + {1'b0, pair.green}) >> 2);
            res.red   = CHAN_W'(({1'b0, above.red} + {1'b0, pair.red}) >> 2);
            res.row_end = (col_pos == last_col);
            res.frame_end = (col_pos == last_col) && (row_pos == last_row);
            made = 1'b1;
         end
      end
      if (col_pos + 1 >= wd) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= ht) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   always @(posedge clock) begin : pixel_sender
      pixel_beat_type beat;
      bit             made;
      pixel_out_type  res;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            downscale_beat(beat.word, made, res);
            if (beat.typed) begin
               block_avg_q.push_back(beat.want);
            end else if (made) begin
               block_avg_q.push_back(res);
            end
            beats_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pixel_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               beat = pixel_q.pop_front();
               req_valid <= 1'b1;
               req_pixel_word <= beat.word;
            end else begin
               req_valid <= 1'b0;
               req_pixel_word <= $urandom;
            end
         end
      end
   end

   always @(posedge clock) begin : block_receiver
      pixel_out_type got;
      pixel_out_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_blue, rsp_green, rsp_red, rsp_row_end, rsp_frame_end};
            if (block_avg_q.size() == 0) begin
               errors++;
               $display({"%0t: unexpected beat, expected none, ",
                         "got b=%0d g=%0d r=%0d row_end=%0d frame_end=%0d"},
                        $time, got.blue, got.green, got.red, got.row_end, got.frame_end);
            end else begin
               want = block_avg_q.pop_front();
               if (got !== want) begin
                  errors++;
                  $display({"%0t: expected b=%0d g=%0d r=%0d row_end=%0d frame_end=%0d, ",
                            "got b=%0d g=%0d r=%0d row_end=%0d frame_end=%0d"},
                           $time, want.blue, want.green, want.red, want.row_end,
                           want.frame_end, got.blue, got.green, got.red, got.row_end,
                           got.frame_end);
               end
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_ask && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   task automatic csr_cycle(input bit wr, input reg_index_type idx, input logic [31:0] data,
                            output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] data);
      logic [31:0] unused;
      csr_cycle(1'b1, idx, data, unused);
      case (idx)
         REG_FRAME_WIDTH:  cfg_width = data[CFG_DIM_W-1:0];
         REG_FRAME_HEIGHT: cfg_height = data[CFG_DIM_W-1:0];
         REG_PIXEL_FORMAT: cfg_format = data[CFG_FMT_W-1:0];
         default: ;
      endcase
      if (idx != REG_SPARE) begin
         col_pos = 0;
         row_pos = 0;
         pair_hold = '0;
      end
   endtask

   task automatic csr_read_check(input reg_index_type idx, input logic [31:0] want);
      logic [31:0] got;
      csr_cycle(1'b0, idx, '0, got);
      if (got !== want) begin
         errors++;
         $display("%0t: register %0d expected %0h, got %0h", $time, idx, want, got);
      end
   endtask

   // drain, then let the pipeline settle past any result-less beats
   task automatic wait_idle();
      while (beats_taken != beats_queued || block_avg_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void add_row(input step_kind_type kind, input reg_index_type idx,
                                   input logic [31:0] value, input logic typed,
                                   input pixel_out_type want);
      stim_row_type row;
      row.kind = kind;
      row.idx = idx;
      row.value = value;
      row.typed = typed;
      row.want = want;
      stim_table.push_back(row);
   endfunction

   function automatic logic [CFG_DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 11))
         0:       return 12'd0;
         1:       return 12'd1;
         2:       return 12'hFFF;
         3:       return CFG_DIM_W'(2 * $urandom_range(1, 3) + 1);
         default: return CFG_DIM_W'($urandom_range(2, 16));
      endcase
   endfunction

   task automatic queue_beat(input logic [PIXEL_W-1:0] word, input logic typed,
                             input pixel_out_type want);
      pixel_beat_type beat;
      beat.word = word;
      beat.typed = typed;
      beat.want = want;
      pixel_q.push_back(beat);
      beats_queued++;
   endtask

   initial begin : main_seq
      pixel_out_type none;
      pixel_out_type white;
      stim_row_type  row;
      int unsigned   sent;
      int unsigned   phase;
      int unsigned   n;
      logic [31:0]   upper;
      none = '0;
      white = {8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1};

      add_row(STEP_READ, REG_FRAME_WIDTH, 32'(FRAME_WIDTH_RESET), 1'b0, none);
      add_row(STEP_READ, REG_FRAME_HEIGHT, 32'(FRAME_HEIGHT_RESET), 1'b0, none);
      add_row(STEP_READ, REG_PIXEL_FORMAT, 32'(PIXEL_FORMAT_RESET), 1'b0, none);
      // sizes below range saturate to a single 2x2 block
      add_row(STEP_WRITE, REG_FRAME_WIDTH, 32'd0, 1'b0, none);
      add_row(STEP_WRITE, REG_FRAME_HEIGHT, 32'd1, 1'b0, none);
      add_row(STEP_READ, REG_FRAME_WIDTH, 32'd0, 1'b0, none);
      repeat (3) add_row(STEP_PIXEL, REG_SPARE, 32'hFFFF_FFFF, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'hFFFF_FFFF, 1'b1, white);
      add_row(STEP_WRITE, REG_PIXEL_FORMAT, 32'(FMT_RGB565), 1'b0, none);
      repeat (3) add_row(STEP_PIXEL, REG_SPARE, 32'h0000_FFFF, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'h0000_FFFF, 1'b1, white);
      repeat (3) add_row(STEP_PIXEL, REG_SPARE, 32'hFFFF_0000, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'hFFFF_0000, 1'b1, {8'h00, 8'h00, 8'h00, 1'b1, 1'b1});
      add_row(STEP_WRITE, REG_PIXEL_FORMAT, 32'(FMT_BGRX32), 1'b0, none);
      repeat (3) add_row(STEP_PIXEL, REG_SPARE, 32'hFFFF_0000, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'hFFFF_0000, 1'b1, {8'h00, 8'h00, 8'hFF, 1'b1, 1'b1});
      // odd last column and row, spare format code
      add_row(STEP_WRITE, REG_PIXEL_FORMAT, 32'(FMT_RGB24_ALT), 1'b0, none);
      add_row(STEP_WRITE, REG_FRAME_WIDTH, 32'd3, 1'b0, none);
      add_row(STEP_WRITE, REG_FRAME_HEIGHT, 32'd3, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'h0012_3456, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'h00FE_DCBA, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'h0001_0203, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'h0080_8080, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'h007F_7F7F, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'h00FF_FFFF, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'h00AA_5500, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'h0055_AA00, 1'b0, none);
      add_row(STEP_PIXEL, REG_SPARE, 32'h0000_0000, 1'b0, none);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i]) begin
         row = stim_table[i];
         case (row.kind)
            STEP_WRITE: begin
               wait_idle();
               csr_write(row.idx, row.value);
            end
            STEP_READ: begin
               wait_idle();
               csr_read_check(row.idx, row.value);
            end
            default: queue_beat(row.value, row.typed, row.want);
         endcase
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_BEATS) begin
         wait_idle();
         calm = (phase == CALM_PHASE);
         upper = $urandom & 32'hFFFF_F000;
         case (phase)
            2: begin
               csr_write(REG_FRAME_WIDTH, upper | 32'd6);
               csr_write(REG_FRAME_HEIGHT, upper | 32'd4);
               hold_ask = 1'b1;
               n = 300;
            end
            CALM_PHASE: begin
               csr_write(REG_FRAME_WIDTH, 32'(CALM_WIDTH));
               csr_write(REG_FRAME_HEIGHT, 32'd2);
               csr_write(REG_PIXEL_FORMAT, 32'($urandom_range(0, 3)));
               n = 2 * CALM_WIDTH;
            end
            5: begin
               csr_write(REG_FRAME_WIDTH, upper | 32'd2);
               csr_write(REG_FRAME_HEIGHT, upper | 32'hFFF);
               n = 400;
            end
            default: begin
               if ($urandom_range(0, 99) < 60) csr_write(REG_FRAME_WIDTH, upper | pick_dim());
               if ($urandom_range(0, 99) < 60) csr_write(REG_FRAME_HEIGHT, upper | pick_dim());
               if ($urandom_range(0, 99) < 60) begin
                  csr_write(REG_PIXEL_FORMAT, upper | 32'($urandom_range(0, 3)));
               end
               if ($urandom_range(0, 99) < 10) csr_write(REG_SPARE, $urandom);
               n = $urandom_range(10, 150);
            end
         endcase
         csr_read_check(REG_FRAME_WIDTH, 32'(cfg_width));
         csr_read_check(REG_FRAME_HEIGHT, 32'(cfg_height));
         csr_read_check(REG_PIXEL_FORMAT, 32'(cfg_format));
         repeat (n) queue_beat($urandom, 1'b0, none);
         sent += n;
         phase++;
      end

      wait_idle();
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
